FILE: hdl/tlik_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the two-link IK core.
// Used by every module of the block; depends on nothing.
package tlik_pkg;

    typedef logic signed [47:0] cval_t;
    typedef logic signed [26:0] ang_t;

    localparam logic [0:0] REG_UPPER_ARM = 1'b0;
    localparam logic [0:0] REG_FOREARM   = 1'b1;

    localparam logic [13:0] LEN_RESET   = 14'd1600;
    localparam ang_t        DEG180_FINE = 27'sd11796480;

    localparam logic signed [27:0] SHOULDER_MIN = -28'sd46080;
    localparam logic signed [27:0] SHOULDER_MAX = 28'sd23040;
    localparam logic signed [27:0] ELBOW_MAX    = 28'sd23040;
    localparam logic signed [27:0] ROUND_HALF   = 28'sd256;

    typedef struct packed {
        logic               valid;
        logic [28:0]        rem;
        logic [30:0]        bits;
        logic [30:0]        quo;
        logic               neg;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } div_t;

    typedef struct packed {
        logic               valid;
        logic [31:0]        rem;
        logic [61:0]        bits;
        logic [30:0]        root;
        logic signed [31:0] cq;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } sqrt_t;

    typedef struct packed {
        logic  valid;
        logic  zero;
        cval_t x;
        cval_t y;
        ang_t  z;
    } cord_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic ang_t atan_fine(input logic [4:0] i);
        ang_t a;
        case (i)
            5'd0:    a = 27'sd2949120;
            5'd1:    a = 27'sd1740967;
            5'd2:    a = 27'sd919879;
            5'd3:    a = 27'sd466945;
            5'd4:    a = 27'sd234379;
            5'd5:    a = 27'sd117304;
            5'd6:    a = 27'sd58666;
            5'd7:    a = 27'sd29335;
            5'd8:    a = 27'sd14668;
            5'd9:    a = 27'sd7334;
            5'd10:   a = 27'sd3667;
            5'd11:   a = 27'sd1833;
            5'd12:   a = 27'sd917;
            5'd13:   a = 27'sd458;
            5'd14:   a = 27'sd229;
            5'd15:   a = 27'sd115;
            5'd16:   a = 27'sd57;
            5'd17:   a = 27'sd29;
            5'd18:   a = 27'sd14;
            5'd19:   a = 27'sd7;
            5'd20:   a = 27'sd4;
            5'd21:   a = 27'sd2;
            5'd22:   a = 27'sd1;
            default: a = 27'sd0;
        endcase
        return a;
    endfunction

endpackage

FILE: hdl/planar_two_link_inverse_kinematics_core.sv
`timescale 1ns / 1ps
// Two-link planar arm inverse kinematics, elbow-positive solution.
// Throughput: one target per cycle; the whole pipeline advances unless the
// output register holds a result that is stalled.
// Reset: asynchronous, active low; clears all valid bits, link lengths go to 1600.
module planar_two_link_inverse_kinematics_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [13:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  x_pos,
    input  logic signed [15:0]  y_pos,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [16:0]  shoulder_angle,
    output logic [14:0]         elbow_angle
);
    import tlik_pkg::*;

    logic               adv;
    logic [13:0]        upper_reg, fore_reg;
    logic [13:0]        l1, l2;
    logic [13:0]        l1_reg, l2_reg;
    logic [28:0]        lsq_reg, den_reg;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [15:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic [30:0]        xx2_reg, yy2_reg;
    logic signed [33:0] num3_reg;
    logic [33:0]        absn;
    div_t               div_init;
    div_t               div_chain [32];

    logic               sa_valid_reg;
    logic [61:0]        qq_reg;
    logic signed [31:0] cq_reg;
    logic signed [15:0] xa_reg, ya_reg;
    sqrt_t              sqrt_init_next, sqrt_init_reg;
    logic               sqrt_vld_reg;
    sqrt_t              sqrt_chain [32];

    logic               k_valid_reg;
    logic signed [46:0] l2cq;
    cval_t              k1_reg, k2_reg, xk_reg, yk_reg, ck_reg, sk_reg;

    cord_t              ct_chain [CORDIC_STAGES + 1];
    cord_t              ce_chain [CORDIC_STAGES + 1];
    cord_t              ck_chain [CORDIC_STAGES + 1];

    cord_t              cs, ce, ckk;
    logic signed [27:0] zt, ze, zk, sh_fine, sh_rnd, el_rnd;
    logic signed [16:0] sh_next;
    logic [14:0]        el_next;
    logic               out_valid_reg;
    logic signed [16:0] shoulder_reg;
    logic [14:0]        elbow_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= LEN_RESET;
            fore_reg  <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UPPER_ARM: upper_reg <= cfg_data;
                REG_FOREARM:   fore_reg  <= cfg_data;
                default:       upper_reg <= upper_reg;
            endcase
        end
    end

    // zero length acts as one
    assign l1 = (upper_reg == '0) ? 14'd1 : upper_reg;
    assign l2 = (fore_reg == '0) ? 14'd1 : fore_reg;

    always_ff @(posedge clk)
    begin
        l1_reg  <= l1;
        l2_reg  <= l2;
        lsq_reg <= 29'(28'(l1) * 28'(l1)) + 29'(28'(l2) * 28'(l2));
        den_reg <= {28'(l1) * 28'(l2), 1'b0};
    end

    // front: squares, cosine numerator, clamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg   <= x_pos;
            y1_reg   <= y_pos;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            xx2_reg  <= 31'(32'(x1_reg) * 32'(x1_reg));
            yy2_reg  <= 31'(32'(y1_reg) * 32'(y1_reg));
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            num3_reg <= $signed(34'(xx2_reg) + 34'(yy2_reg) - 34'(lsq_reg));
        end
    end

    // dividend is mag * 2^30 + den / 2
    always_comb
    begin
        absn           = num3_reg[33] ? 34'(-num3_reg) : 34'(num3_reg);
        div_init       = '0;
        div_init.valid = s3_valid_reg;
        div_init.neg   = num3_reg[33];
        div_init.x     = x3_reg;
        div_init.y     = y3_reg;
        if (absn > 34'(den_reg))
        begin
            div_init.rem  = 29'(den_reg[28:1]);
            div_init.bits = {den_reg[0], 2'b00, den_reg[28:1]};
        end
        else
        begin
            div_init.rem  = 29'(absn[28:1]);
            div_init.bits = {absn[0], 2'b00, den_reg[28:1]};
        end
    end

    // div_init is registered by the first cell
    assign div_chain[0] = div_init;

    for (genvar i = 0; i < 31; i++)
    begin : g_div
        tlik_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .den   (den_reg),
            .d     (div_chain[i]),
            .q     (div_chain[i + 1])
        );
    end

    // cosine, its square, then sine radicand
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
            sqrt_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            sa_valid_reg <= div_chain[31].valid;
            sqrt_vld_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qq_reg        <= 62'(div_chain[31].quo) * 62'(div_chain[31].quo);
            cq_reg        <= div_chain[31].neg ? -$signed(32'(div_chain[31].quo))
                                               : $signed(32'(div_chain[31].quo));
            xa_reg        <= div_chain[31].x;
            ya_reg        <= div_chain[31].y;
            sqrt_init_reg <= sqrt_init_next;
        end
    end

    always_comb
    begin
        sqrt_init_next      = '0;
        sqrt_init_next.bits = 62'(62'h1000_0000_0000_0000 - qq_reg);
        sqrt_init_next.cq   = cq_reg;
        sqrt_init_next.x    = xa_reg;
        sqrt_init_next.y    = ya_reg;
    end

    always_comb
    begin
        sqrt_chain[0]       = sqrt_init_reg;
        sqrt_chain[0].valid = sqrt_vld_reg;
    end

    for (genvar i = 0; i < 31; i++)
    begin : g_sqrt
        tlik_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d     (sqrt_chain[i]),
            .q     (sqrt_chain[i + 1])
        );
    end

    // second atan2 arguments: l1 + l2 cos e, l2 sin e
    assign l2cq = $signed({1'b0, l2_reg}) * sqrt_chain[31].cq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_valid_reg <= 1'b0;
        else if (adv)
            k_valid_reg <= sqrt_chain[31].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k1_reg <= $signed({4'd0, l1_reg, 30'd0}) + 48'(l2cq);
            k2_reg <= $signed(48'(l2_reg * 45'(sqrt_chain[31].root)));
            xk_reg <= 48'(sqrt_chain[31].x);
            yk_reg <= 48'(sqrt_chain[31].y);
            ck_reg <= 48'(sqrt_chain[31].cq);
            sk_reg <= $signed(48'(sqrt_chain[31].root));
        end
    end

    tlik_norm u_norm_t (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (k_valid_reg),
        .x_in (xk_reg), .y_in (yk_reg), .q (ct_chain[0])
    );

    tlik_norm u_norm_e (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (k_valid_reg),
        .x_in (ck_reg), .y_in (sk_reg), .q (ce_chain[0])
    );

    tlik_norm u_norm_k (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (k_valid_reg),
        .x_in (k1_reg), .y_in (k2_reg), .q (ck_chain[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        tlik_cordic_cell #(.STAGE(i)) u_target (
            .clk (clk), .rst_n (rst_n), .en (adv), .d (ct_chain[i]), .q (ct_chain[i + 1])
        );
        tlik_cordic_cell #(.STAGE(i)) u_elbow (
            .clk (clk), .rst_n (rst_n), .en (adv), .d (ce_chain[i]), .q (ce_chain[i + 1])
        );
        tlik_cordic_cell #(.STAGE(i)) u_offset (
            .clk (clk), .rst_n (rst_n), .en (adv), .d (ck_chain[i]), .q (ck_chain[i + 1])
        );
    end

    // round to 1/128 degree and clamp
    always_comb
    begin
        cs      = ct_chain[CORDIC_STAGES];
        ce      = ce_chain[CORDIC_STAGES];
        ckk     = ck_chain[CORDIC_STAGES];
        zt      = cs.zero  ? '0 : 28'(cs.z);
        ze      = ce.zero  ? '0 : 28'(ce.z);
        zk      = ckk.zero ? '0 : 28'(ckk.z);
        sh_fine = zt - zk;
        sh_rnd  = (sh_fine + ROUND_HALF) >>> 9;
        el_rnd  = (ze + ROUND_HALF) >>> 9;
        if (sh_rnd < SHOULDER_MIN)
            sh_next = 17'(SHOULDER_MIN);
        else if (sh_rnd > SHOULDER_MAX)
            sh_next = 17'(SHOULDER_MAX);
        else
            sh_next = 17'(sh_rnd);
        if (el_rnd[27])
            el_next = '0;
        else if (el_rnd > ELBOW_MAX)
            el_next = 15'(ELBOW_MAX);
        else
            el_next = 15'(el_rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= cs.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            shoulder_reg <= sh_next;
            elbow_reg    <= el_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign shoulder_angle = shoulder_reg;
    assign elbow_angle    = elbow_reg;

`ifndef SYNTH
    a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (28'(elbow_angle) <= ELBOW_MAX) &&
                      (28'(shoulder_angle) >= SHOULDER_MIN) &&
                      (28'(shoulder_angle) <= SHOULDER_MAX))
        else $error("result outside joint range");

    a_stall_holds_front : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && in_stall) |=> s1_valid_reg)
        else $error("front stage lost an item during stall");

    a_free_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty output register");
`endif

endmodule

FILE: hdl/tlik_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: produces one quotient bit per cycle while en is high.
// Depends on tlik_pkg.
module tlik_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [28:0]    den,
    input  tlik_pkg::div_t d,
    output tlik_pkg::div_t q
);
    import tlik_pkg::*;

    logic [29:0] r_sh;
    logic        ge;
    div_t        q_next;
    div_t        q_reg;
    logic        valid_reg;

    always_comb
    begin
        r_sh          = {d.rem, d.bits[30]};
        ge            = (r_sh >= {1'b0, den});
        q_next        = d;
        q_next.rem    = ge ? 29'(r_sh - {1'b0, den}) : r_sh[28:0];
        q_next.bits   = {d.bits[29:0], 1'b0};
        q_next.quo    = {d.quo[29:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    always_comb
    begin
        q       = q_reg;
        q.valid = valid_reg;
    end

endmodule

FILE: hdl/tlik_sqrt_cell.sv
`timescale 1ns / 1ps
// One digit-by-digit square root cell: takes two radicand bits, gives one root bit.
// Depends on tlik_pkg.
module tlik_sqrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  tlik_pkg::sqrt_t d,
    output tlik_pkg::sqrt_t q
);
    import tlik_pkg::*;

    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        ge;
    sqrt_t       q_next;
    sqrt_t       q_reg;
    logic        valid_reg;

    always_comb
    begin
        rem_sh       = {d.rem, d.bits[61:60]};
        trial        = {1'b0, d.root, 2'b01};
        ge           = (rem_sh >= trial);
        q_next       = d;
        q_next.rem   = ge ? 32'(rem_sh - trial) : rem_sh[31:0];
        q_next.bits  = {d.bits[59:0], 2'b00};
        q_next.root  = {d.root[29:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    always_comb
    begin
        q       = q_reg;
        q.valid = valid_reg;
    end

endmodule

FILE: hdl/tlik_norm.sv
`timescale 1ns / 1ps
// Front end of one arctangent: half-plane fold, then scale so the larger
// magnitude lands in [2^40, 2^41). Five register stages. Depends on tlik_pkg.
module tlik_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  tlik_pkg::cval_t x_in,
    input  tlik_pkg::cval_t y_in,
    output tlik_pkg::cord_t q
);
    import tlik_pkg::*;

    logic [4:0]  vld_reg;
    cord_t       c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    cord_t       c1_next, c5_next;
    logic [47:0] m2_reg, m2_next;
    logic [5:0]  nz3_reg, nz3_next;
    logic [2:0]  pos3_reg [6];
    logic [2:0]  pos3_next [6];
    logic [5:0]  p4_reg, p4_next;
    cval_t       ya;

    // fold the left half plane onto the right one
    always_comb
    begin
        c1_next       = '0;
        c1_next.valid = in_vld;
        c1_next.zero  = (x_in == '0) && (y_in == '0);
        if (x_in[47])
        begin
            c1_next.x = -x_in;
            c1_next.y = -y_in;
            c1_next.z = y_in[47] ? -DEG180_FINE : DEG180_FINE;
        end
        else
        begin
            c1_next.x = x_in;
            c1_next.y = y_in;
            c1_next.z = '0;
        end
    end

    always_comb
    begin
        ya      = c1_reg.y[47] ? -c1_reg.y : c1_reg.y;
        m2_next = (c1_reg.x > ya) ? c1_reg.x : ya;
    end

    // leading one per byte
    always_comb
    begin
        for (int g = 0; g < 6; g++)
        begin
            nz3_next[g]  = |m2_reg[8*g +: 8];
            pos3_next[g] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (m2_reg[8*g + b])
                    pos3_next[g] = 3'(b);
            end
        end
    end

    always_comb
    begin
        p4_next = '0;
        for (int g = 0; g < 6; g++)
        begin
            if (nz3_reg[g])
                p4_next = {3'(g), pos3_reg[g]};
        end
    end

    always_comb
    begin
        c5_next = c4_reg;
        if (p4_reg <= 6'd40)
        begin
            c5_next.x = c4_reg.x <<< (6'd40 - p4_reg);
            c5_next.y = c4_reg.y <<< (6'd40 - p4_reg);
        end
        else
        begin
            c5_next.x = c4_reg.x >>> (p4_reg - 6'd40);
            c5_next.y = c4_reg.y >>> (p4_reg - 6'd40);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg  <= c1_next;
            c2_reg  <= c1_reg;
            m2_reg  <= m2_next;
            c3_reg  <= c2_reg;
            nz3_reg <= nz3_next;
            for (int g = 0; g < 6; g++)
                pos3_reg[g] <= pos3_next[g];
            c4_reg  <= c3_reg;
            p4_reg  <= p4_next;
            c5_reg  <= c5_next;
        end
    end

    always_comb
    begin
        q       = c5_reg;
        q.valid = vld_reg[4];
    end

endmodule

FILE: hdl/tlik_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC vectoring cell with a fixed shift and a fixed angle step.
// Depends on tlik_pkg.
module tlik_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  tlik_pkg::cord_t d,
    output tlik_pkg::cord_t q
);
    import tlik_pkg::*;

    cval_t xs, ys;
    cord_t q_next;
    cord_t q_reg;
    logic  valid_reg;

    always_comb
    begin
        xs     = d.x >>> STAGE;
        ys     = d.y >>> STAGE;
        q_next = d;
        if (!d.y[47])
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + atan_fine(5'(STAGE));
        end
        else
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - atan_fine(5'(STAGE));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= d.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    always_comb
    begin
        q       = q_reg;
        q.valid = valid_reg;
    end

endmodule
